[rtl/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/smta_pkg.sv]
package smta_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int CFG_IDX_W   = 3;

  // item kinds
  localparam logic [2:0] KIND_WR_A = 3'd0;
  localparam logic [2:0] KIND_WR_B = 3'd1;
  localparam logic [2:0] KIND_WR_C = 3'd2;
  localparam logic [2:0] KIND_RUN  = 3'd3;
  localparam logic [2:0] KIND_RD_C = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM  = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_MAG,
    ST_PLO,
    ST_PHI,
    ST_QSUM,
    ST_TERM,
    ST_WB
  } state_t;

  typedef struct packed {
    logic item_go;
    logic run_go;
    logic mac_issue;
    logic acc_clr;
    logic ld_mag;
    logic ld_plo;
    logic ld_phi;
    logic ld_q;
    logic ld_term;
    logic c_wb;
    logic clr_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

[rtl/smta_ram.sv]
module smta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/smta_ctrl.sv]
module smta_ctrl import smta_pkg::*; #(
  parameter  int MAX_DIM = MAX_DIM_DEF,
  localparam int IW      = $clog2(MAX_DIM),
  localparam int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           kind,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [4:0]           cfg_dim,
  input  status_t              st,
  output logic                 busy,
  output cmd_t                 cmd,
  output logic [IW-1:0]        i_idx,
  output logic [IW-1:0]        j_idx,
  output logic [IW-1:0]        k_idx,
  output logic [AW-1:0]        clr_idx
);

  state_t        state_r, state_nxt;
  logic [4:0]    rows_a_r, rows_b_r, inner_r;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] i_lim, j_lim, k_lim;

  function automatic logic [IW-1:0] dim_lim(input logic [4:0] d);
    if (d == 5'd0) begin
      return '0;
    end else if (32'(d) > MAX_DIM) begin
      return IW'(MAX_DIM - 1);
    end else begin
      return IW'(d - 5'd1);
    end
  endfunction

  assign i_lim = dim_lim(rows_a_r);
  assign j_lim = dim_lim(rows_b_r);
  assign k_lim = dim_lim(inner_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= 5'd16;
      rows_b_r <= 5'd16;
      inner_r  <= 5'd16;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ROWS_A: rows_a_r <= cfg_dim;
        CFG_ROWS_B: rows_b_r <= cfg_dim;
        CFG_INNER:  inner_r  <= cfg_dim;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    clr_nxt   = clr_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == AW'(MAX_DIM * MAX_DIM - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.item_go = start;
        if (start && kind == KIND_RUN) begin
          cmd.run_go = 1'b1;
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          state_nxt  = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.acc_clr   = (k_r == '0);
        if (k_r == k_lim) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) begin
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.ld_mag = 1'b1;
        state_nxt  = ST_PLO;
      end
      ST_PLO: begin
        cmd.ld_plo = 1'b1;
        state_nxt  = ST_PHI;
      end
      ST_PHI: begin
        cmd.ld_phi = 1'b1;
        state_nxt  = ST_QSUM;
      end
      ST_QSUM: begin
        cmd.ld_q  = 1'b1;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        cmd.ld_term = 1'b1;
        state_nxt   = ST_WB;
      end
      ST_WB: begin
        cmd.c_wb  = 1'b1;
        state_nxt = ST_MAC;
        if (j_r == j_lim) begin
          j_nxt = '0;
          if (i_r == i_lim) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy    = (state_r != ST_IDLE);
  assign i_idx   = i_r;
  assign j_idx   = j_r;
  assign k_idx   = k_r;
  assign clr_idx = clr_r;

endmodule

[rtl/smta_dp.sv]
module smta_dp import smta_pkg::*; #(
  parameter  int MAX_DIM = MAX_DIM_DEF,
  localparam int IW      = $clog2(MAX_DIM),
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              st,
  input  in_item_t             in_item,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [IW-1:0]        i_idx,
  input  logic [IW-1:0]        j_idx,
  input  logic [IW-1:0]        k_idx,
  input  logic [AW-1:0]        clr_idx,
  output logic                 out_valid,
  output out_item_t            out_item
);

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  logic [31:0] scale_r;
  logic        accum_r;

  logic          in_range;
  logic [AW-1:0] item_addr, a_addr, b_addr, c_run_addr;
  logic          a_we, b_we;
  logic          c_we, c_re;
  logic [AW-1:0] c_wr_addr, c_rd_addr;
  logic [31:0]   c_wr_data;
  logic [31:0]   a_q, b_q, c_q;

  logic               v1_r, v2_r;
  logic signed [63:0] prod_r;
  logic [63:0]        acc_r;
  logic [64:0]        acc_sum;
  logic               sat_acc;

  logic [63:0] ma_r, plo_r, phi_r, q_r, neg_q;
  logic [31:0] mb_r, rnd_r;
  logic        neg_r;
  logic [31:0] term, term_r;
  logic        sat_term;
  logic [32:0] wb_sum;
  logic        sat_wb;
  logic [31:0] wb_value;

  logic sat_run_r, sat_flag_r;
  logic out_valid_r, rd_pend_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'h0001_0000;
      accum_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_SCALE: scale_r <= cfg_data;
        CFG_ACCUM: accum_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // addressing
  assign in_range   = (32'(in_item.row) < MAX_DIM) && (32'(in_item.col) < MAX_DIM);
  assign item_addr  = AW'(32'(in_item.row) * MAX_DIM + 32'(in_item.col));
  assign a_addr     = AW'(32'(i_idx) * MAX_DIM + 32'(k_idx));
  assign b_addr     = AW'(32'(j_idx) * MAX_DIM + 32'(k_idx));
  assign c_run_addr = AW'(32'(i_idx) * MAX_DIM + 32'(j_idx));

  assign a_we = cmd.item_go && in_item.kind == KIND_WR_A && in_range;
  assign b_we = cmd.item_go && in_item.kind == KIND_WR_B && in_range;

  always_comb begin
    c_we      = 1'b0;
    c_wr_addr = item_addr;
    c_wr_data = in_item.value;
    if (cmd.clr_wr) begin
      c_we      = 1'b1;
      c_wr_addr = clr_idx;
      c_wr_data = '0;
    end else if (cmd.c_wb) begin
      c_we      = 1'b1;
      c_wr_addr = c_run_addr;
      c_wr_data = wb_value;
    end else begin
      c_we = cmd.item_go && in_item.kind == KIND_WR_C && in_range;
    end
  end

  assign c_re      = cmd.ld_mag || (cmd.item_go && in_item.kind == KIND_RD_C && in_range);
  assign c_rd_addr = cmd.ld_mag ? c_run_addr : item_addr;

  smta_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_a_ram (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (item_addr),
    .wr_data (in_item.value),
    .rd_en   (cmd.mac_issue),
    .rd_addr (a_addr),
    .rd_data (a_q)
  );

  smta_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_b_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (item_addr),
    .wr_data (in_item.value),
    .rd_en   (cmd.mac_issue),
    .rd_addr (b_addr),
    .rd_data (b_q)
  );

  smta_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_c_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data),
    .rd_en   (c_re),
    .rd_addr (c_rd_addr),
    .rd_data (c_q)
  );

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  assign acc_sum = {acc_r[63], acc_r} + {prod_r[63], prod_r};
  assign sat_acc = v2_r && (acc_sum[64] != acc_sum[63]);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= $signed({{32{a_q[31]}}, a_q}) * $signed({{32{b_q[31]}}, b_q});
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      if (acc_sum[64] != acc_sum[63]) begin
        acc_r <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc_r <= acc_sum[63:0];
      end
    end
  end

  assign st.pipe_busy = v1_r || v2_r;

  // scaling, rounding and saturation
  assign neg_q = 64'd0 - q_r;

  always_comb begin
    sat_term = 1'b0;
    term     = q_r[31:0];
    if (neg_r) begin
      if (q_r > 64'h0000_0000_8000_0000) begin
        sat_term = 1'b1;
        term     = Q_MIN;
      end else begin
        term = neg_q[31:0];
      end
    end else if (q_r > 64'h0000_0000_7FFF_FFFF) begin
      sat_term = 1'b1;
      term     = Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_mag) begin
      ma_r  <= acc_r[63] ? (64'd0 - acc_r) : acc_r;
      mb_r  <= scale_r[31] ? (32'd0 - scale_r) : scale_r;
      neg_r <= acc_r[63] ^ scale_r[31];
    end
    if (cmd.ld_plo) begin
      plo_r <= {32'd0, ma_r[31:0]} * {32'd0, mb_r};
    end
    if (cmd.ld_phi) begin
      phi_r <= {32'd0, ma_r[63:32]} * {32'd0, mb_r};
      rnd_r <= 32'((plo_r + 64'h0000_0000_8000_0000) >> 32);
    end
    if (cmd.ld_q) begin
      q_r <= phi_r + {32'd0, rnd_r};
    end
    if (cmd.ld_term) begin
      term_r <= term;
    end
  end

  // write-back with optional accumulation onto C
  assign wb_sum = {term_r[31], term_r} + {c_q[31], c_q};
  assign sat_wb = accum_r && (wb_sum[32] != wb_sum[31]);

  always_comb begin
    if (!accum_r) begin
      wb_value = term_r;
    end else if (wb_sum[32] != wb_sum[31]) begin
      wb_value = wb_sum[32] ? Q_MIN : Q_MAX;
    end else begin
      wb_value = wb_sum[31:0];
    end
  end

  // saturation flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_run_r  <= 1'b0;
      sat_flag_r <= 1'b0;
    end else begin
      if (cmd.run_go) begin
        sat_run_r <= 1'b0;
      end else if (sat_acc || (cmd.ld_term && sat_term) || (cmd.c_wb && sat_wb)) begin
        sat_run_r <= 1'b1;
      end
      if (cmd.finish) begin
        sat_flag_r <= sat_run_r || sat_wb;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= (cmd.item_go && in_item.kind != KIND_RUN) || cmd.finish;
      rd_pend_r   <= cmd.item_go && in_item.kind == KIND_RD_C && in_range;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_item.result_value = rd_pend_r ? c_q : '0;
  assign out_item.saturated    = sat_flag_r;

endmodule

[rtl/scaled_matmul_transposed_accumulate_core.sv]
// channel   direction  handshake              payload
// in_       input      start high, busy low   in_item    (in_item_t)
// out_      output     out_valid, one cycle   out_item   (out_item_t)
// cfg_      input      cfg_valid, cfg_ready   cfg_index, cfg_data
//
// write and read items: one per cycle while busy is low, result in the following cycle
// run item: paced by the single A/B read port pair feeding the multiply-accumulate
// and by the MAG, PLO, PHI, QSUM, TERM and WB steps that scale each element
// after reset a clearing pass zeroes every C cell, busy held high
// configuration is taken in every cycle; results cannot be stalled
`include "assert_macros.svh"

module scaled_matmul_transposed_accumulate_core import smta_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  cmd_t          cmd;
  status_t       st;
  logic          cfg_wr;
  logic [IW-1:0] i_idx, j_idx, k_idx;
  logic [AW-1:0] clr_idx;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  smta_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_item.kind),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_dim   (cfg_data[4:0]),
    .st        (st),
    .busy      (busy),
    .cmd       (cmd),
    .i_idx     (i_idx),
    .j_idx     (j_idx),
    .k_idx     (k_idx),
    .clr_idx   (clr_idx)
  );

  smta_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_item   (in_item),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .i_idx     (i_idx),
    .j_idx     (j_idx),
    .k_idx     (k_idx),
    .clr_idx   (clr_idx),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `ASSERT_NEXT(a_item_result, start && !busy && in_item.kind != KIND_RUN, out_valid)
  `ASSERT_NEXT(a_run_result, cmd.finish, out_valid && !busy)
  `ASSERT_IMPL(a_drain_before_scale, cmd.ld_mag, !st.pipe_busy)

endmodule

[tb/sv/tb_scaled_matmul_transposed_accumulate_core.sv]
module tb_scaled_matmul_transposed_accumulate_core;
  import smta_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  localparam int CELLS = DIM * DIM;
  localparam int ITEM_GOAL = 1300;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_HALF = 32'sd32768;
  localparam logic signed [31:0] Q_MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MINV = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predicted block state and configuration
  logic signed [31:0] a_mem [CELLS];
  logic signed [31:0] b_mem [CELLS];
  logic signed [31:0] c_mem [CELLS];
  logic sat_seen;
  logic [4:0] m_rows_a;
  logic [4:0] m_rows_b;
  logic [4:0] m_inner;
  logic signed [31:0] m_scale;
  logic m_accum;

  bit a_loaded [CELLS];
  bit b_loaded [CELLS];
  in_item_t pending_items [$];
  out_item_t result_due_q [$];
  out_item_t want;
  int items_sent = 0;
  int errors = 0;
  int burst_left;
  int gap_left;

  scaled_matmul_transposed_accumulate_core dut (
    .clk,
    .rst_n,
    .start,
    .busy,
    .in_item,
    .out_valid,
    .out_item,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_scaled_matmul_transposed_accumulate_core: done, errors");
    $finish;
  end

  function automatic int eff_dim(input logic [4:0] d);
    if (d == 5'd0) return 1;
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  function automatic logic signed [63:0] add_clip64(input logic signed [63:0] acc,
                                                   input logic signed [63:0] p,
                                                   inout logic hit);
    logic signed [64:0] s;
    s = {acc[63], acc} + {p[63], p};
    if (s[64] != s[63]) begin
      hit = 1'b1;
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Q32.32 sum times Q16.16 scale, magnitude rounded half away from zero
  function automatic logic signed [31:0] scale_q16(input logic signed [63:0] sum,
                                                  input logic signed [31:0] s,
                                                  inout logic hit);
    logic [63:0] mag_sum;
    logic [31:0] mag_s;
    logic [95:0] prod;
    logic [63:0] q;
    logic neg;
    mag_sum = sum[63] ? -sum : sum;
    mag_s = s[31] ? -s : s;
    prod = {32'd0, mag_sum} * {64'd0, mag_s};
    prod = prod + 96'h8000_0000;
    q = prod[95:32];
    neg = sum[63] ^ s[31];
    if (neg) begin
      if (q > 64'h8000_0000) begin
        hit = 1'b1;
        return Q_MINV;
      end
      return -q[31:0];
    end
    if (q > 64'h7fff_ffff) begin
      hit = 1'b1;
      return Q_MAXV;
    end
    return q[31:0];
  endfunction

  function automatic void run_gemm();
    int ra, rb, nk, i, j, k;
    logic hit;
    logic signed [63:0] acc;
    logic signed [63:0] prod64;
    logic signed [31:0] term;
    logic signed [31:0] old_c;
    logic signed [32:0] wide;
    ra = eff_dim(m_rows_a);
    rb = eff_dim(m_rows_b);
    nk = eff_dim(m_inner);
    hit = 1'b0;
    for (i = 0; i < ra; i++) begin
      for (j = 0; j < rb; j++) begin
        acc = '0;
        for (k = 0; k < nk; k++) begin
          prod64 = a_mem[i * DIM + k] * b_mem[j * DIM + k];
          acc = add_clip64(acc, prod64, hit);
        end
        term = scale_q16(acc, m_scale, hit);
        if (m_accum) begin
          old_c = c_mem[i * DIM + j];
          wide = {term[31], term} + {old_c[31], old_c};
          if (wide[32] != wide[31]) begin
            hit = 1'b1;
            term = wide[32] ? Q_MINV : Q_MAXV;
          end else begin
            term = wide[31:0];
          end
        end
        c_mem[i * DIM + j] = term;
      end
    end
    sat_seen = hit;
  endfunction

  function automatic out_item_t gemm_step(input in_item_t it);
    out_item_t r;
    logic [7:0] addr;
    addr = {it.row, it.col};
    r.result_value = '0;
    case (it.kind)
      KIND_WR_A: a_mem[addr] = it.value;
      KIND_WR_B: b_mem[addr] = it.value;
      KIND_WR_C: c_mem[addr] = it.value;
      KIND_RUN: run_gemm();
      KIND_RD_C: r.result_value = c_mem[addr];
      default: ;
    endcase
    r.saturated = sat_seen;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MAXV;
          1: return Q_MINV;
          2: return '0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 'h7ffff) - 'h40000;
      4, 5: return $urandom_range(0, 'h1ffffff) - 'h1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return Q_ONE;
      1: return -Q_ONE;
      2: return Q_MAXV;
      3: return Q_MINV;
      4: return '0;
      5, 6: return $urandom;
      default: return $urandom_range(0, 'h3ffff) - 'h20000;
    endcase
  endfunction

  function automatic logic [4:0] rand_dim();
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'($urandom_range(17, 31));
      2: return 5'($urandom_range(9, 16));
      3, 4, 5: return 5'($urandom_range(5, 8));
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic queue_item(input logic [2:0] kind, input logic [3:0] row,
                            input logic [3:0] col, input logic signed [31:0] value);
    in_item_t it;
    it.kind = kind;
    it.row = row;
    it.col = col;
    it.value = value;
    pending_items.insert(pending_items.size(), it);
    if (kind == KIND_WR_A) a_loaded[{row, col}] = 1'b1;
    if (kind == KIND_WR_B) b_loaded[{row, col}] = 1'b1;
    if (kind <= KIND_RD_C) items_sent++;
  endtask

  // every operand a run will read is written first, some are rewritten
  task automatic load_operands();
    int ra, rb, nk, i, k;
    ra = eff_dim(m_rows_a);
    rb = eff_dim(m_rows_b);
    nk = eff_dim(m_inner);
    for (i = 0; i < ra; i++)
      for (k = 0; k < nk; k++)
        if (!a_loaded[i * DIM + k] || $urandom_range(0, 5) == 0)
          queue_item(KIND_WR_A, 4'(i), 4'(k), rand_q());
    for (i = 0; i < rb; i++)
      for (k = 0; k < nk; k++)
        if (!b_loaded[i * DIM + k] || $urandom_range(0, 5) == 0)
          queue_item(KIND_WR_B, 4'(i), 4'(k), rand_q());
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || result_due_q.size() != 0 || start !== 1'b0 ||
           busy !== 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    case (idx)
      CFG_ROWS_A: m_rows_a = data[4:0];
      CFG_ROWS_B: m_rows_b = data[4:0];
      CFG_INNER: m_inner = data[4:0];
      CFG_SCALE: m_scale = data;
      CFG_ACCUM: m_accum = data[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [4:0] ra, input logic [4:0] rb,
                              input logic [4:0] nk, input logic signed [31:0] sc,
                              input logic acc);
    write_reg(CFG_ROWS_A, {27'd0, ra});
    write_reg(CFG_ROWS_B, {27'd0, rb});
    write_reg(CFG_INNER, {27'd0, nk});
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_ACCUM, {31'd0, acc});
    cfg_valid <= 1'b0;
  endtask

  // driver: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        result_due_q.insert(result_due_q.size(), gemm_step(in_item));
        void'(pending_items.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          start <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (result_due_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: value %h sat %b", $time,
                 out_item.result_value, out_item.saturated);
      end else begin
        want = result_due_q.pop_front();
        if (out_item.result_value !== want.result_value) begin
          errors++;
          $display("%0t: result_value expected %h got %h", $time, want.result_value,
                   out_item.result_value);
        end
        if (out_item.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated expected %b got %b", $time, want.saturated,
                   out_item.saturated);
        end
      end
    end
  end

  initial begin
    int phase, rounds, ra_n, rb_n;
    for (int n = 0; n < CELLS; n++) begin
      a_mem[n] = '0;
      b_mem[n] = '0;
      c_mem[n] = '0;
      a_loaded[n] = 1'b0;
      b_loaded[n] = 1'b0;
    end
    sat_seen = 1'b0;
    m_rows_a = 5'd16;
    m_rows_b = 5'd16;
    m_inner = 5'd16;
    m_scale = Q_ONE;
    m_accum = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // reset contents, spare kinds, field extremes
    queue_item(KIND_RD_C, 4'd0, 4'd0, Q_MAXV);
    queue_item(KIND_RD_C, 4'd15, 4'd15, Q_MINV);
    queue_item(KIND_SPARE_LO, 4'd15, 4'd0, Q_MAXV);
    queue_item(KIND_SPARE_HI, 4'd0, 4'd15, Q_MINV);
    queue_item(KIND_WR_C, 4'd15, 4'd15, Q_MAXV);
    queue_item(KIND_WR_C, 4'd0, 4'd15, Q_MINV);
    queue_item(KIND_RD_C, 4'd15, 4'd15, '0);
    queue_item(KIND_RD_C, 4'd0, 4'd15, '0);
    wait_drained();

    // 64-bit accumulator overflow, then a sum of one half
    program_regs(5'd1, 5'd1, 5'd2, Q_ONE, 1'b0);
    queue_item(KIND_WR_A, 4'd0, 4'd0, Q_MINV);
    queue_item(KIND_WR_A, 4'd0, 4'd1, Q_MINV);
    queue_item(KIND_WR_B, 4'd0, 4'd0, Q_MINV);
    queue_item(KIND_WR_B, 4'd0, 4'd1, Q_MINV);
    queue_item(KIND_RUN, 4'd0, 4'd0, '0);
    queue_item(KIND_RD_C, 4'd0, 4'd0, '0);
    queue_item(KIND_SPARE_LO, 4'd0, 4'd0, '0);
    queue_item(KIND_WR_A, 4'd0, 4'd1, Q_MAXV);
    queue_item(KIND_RUN, 4'd0, 4'd0, '0);
    queue_item(KIND_RD_C, 4'd0, 4'd0, '0);
    wait_drained();

    // negative clip, then accumulate onto the most negative C
    program_regs(5'd1, 5'd1, 5'd1, -Q_ONE, 1'b1);
    queue_item(KIND_WR_C, 4'd0, 4'd0, Q_MINV);
    queue_item(KIND_RUN, 4'd0, 4'd0, '0);
    queue_item(KIND_RD_C, 4'd0, 4'd0, '0);
    wait_drained();

    // rounding ties of both signs
    program_regs(5'd1, 5'd1, 5'd1, Q_HALF, 1'b0);
    queue_item(KIND_WR_A, 4'd0, 4'd0, 32'sd256);
    queue_item(KIND_WR_B, 4'd0, 4'd0, 32'sd256);
    queue_item(KIND_RUN, 4'd0, 4'd0, '0);
    queue_item(KIND_RD_C, 4'd0, 4'd0, '0);
    wait_drained();
    program_regs(5'd1, 5'd1, 5'd1, -Q_HALF, 1'b0);
    queue_item(KIND_RUN, 4'd0, 4'd0, '0);
    queue_item(KIND_RD_C, 4'd0, 4'd0, '0);

    for (phase = 0; items_sent < ITEM_GOAL; phase++) begin
      wait_drained();
      case (phase)
        0: program_regs(5'd31, 5'd0, 5'd16, Q_MAXV, 1'b1);
        1: program_regs(5'd1, 5'd16, 5'd0, Q_MINV, 1'b0);
        2: program_regs(5'd16, 5'd16, 5'd16, rand_scale(), 1'b1);
        default: program_regs(rand_dim(), rand_dim(), rand_dim(), rand_scale(),
                              1'($urandom_range(0, 1)));
      endcase
      ra_n = eff_dim(m_rows_a);
      rb_n = eff_dim(m_rows_b);
      rounds = $urandom_range(1, 4);
      repeat (rounds) begin
        load_operands();
        repeat ($urandom_range(0, 4))
          queue_item(KIND_WR_C, 4'($urandom_range(0, ra_n - 1)),
                     4'($urandom_range(0, rb_n - 1)), rand_q());
        queue_item(KIND_RUN, 4'($urandom), 4'($urandom), $urandom);
        repeat ($urandom_range(1, 6))
          queue_item(KIND_RD_C, 4'($urandom_range(0, ra_n - 1)),
                     4'($urandom_range(0, rb_n - 1)), rand_q());
        case ($urandom_range(0, 3))
          0: queue_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 4'($urandom),
                        4'($urandom), rand_q());
          1: queue_item(KIND_RD_C, 4'($urandom), 4'($urandom), rand_q());
          2: queue_item(($urandom_range(0, 1) != 0) ? KIND_WR_A : KIND_WR_B, 4'($urandom),
                        4'($urandom), rand_q());
          default: ;
        endcase
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_scaled_matmul_transposed_accumulate_core: done, clean");
    end else begin
      $display("tb_scaled_matmul_transposed_accumulate_core: done, errors");
    end
    $finish;
  end

endmodule
